// File: rtl/core/bmfp_pkg.sv
package bmfp_pkg;

  localparam int WINDOW    = 15;
  localparam int MAX_BURST = 5;

  localparam int T_W    = 63;                       // timestamp width
  localparam int P_W    = 32;                       // period width
  localparam int SLOT_W = $clog2(WINDOW);           // ring slot tag
  localparam int CNT_W  = $clog2(WINDOW + 1);       // fill count
  localparam int DIV_W  = $clog2(MAX_BURST + 2);    // burst_count + 1
  localparam int DIV_STEPS = P_W;
  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic [2:0]     frame_index;
    logic [2:0]     burst_count;
    logic [T_W-1:0] timestamp;
    logic           pace;
  } in_t;

  typedef struct packed {
    logic           accepted;
    logic           wait_valid;
    logic [T_W-1:0] deadline;
    logic [P_W-1:0] median_period;
    logic [P_W-1:0] frame_interval;
  } out_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_DEL,
    CELL_INS
  } cell_op_e;

  // One sorted sample: its value and the ring slot it came from.
  typedef struct packed {
    logic [P_W-1:0]    val;
    logic [SLOT_W-1:0] slot;
  } cell_data_t;

  typedef struct packed {
    cell_op_e          op;
    cell_data_t        ins;
    logic [SLOT_W-1:0] del_slot;
  } cell_ctrl_t;

endpackage

// File: rtl/core/bmfp_cell.sv
module bmfp_cell
  import bmfp_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occupied_i,
  input  cell_data_t left_i,
  input  cell_data_t right_i,
  input  logic       left_gt_i,
  input  logic       del_chain_i,
  output logic       gt_o,
  output logic       del_chain_o,
  output cell_data_t data_o
);

  cell_data_t data_q;
  logic       match;

  // Empty cells sort as larger than anything.
  assign gt_o        = !occupied_i || (data_q.val > ctrl_i.ins.val);
  assign match       = occupied_i && (data_q.slot == ctrl_i.del_slot);
  assign del_chain_o = del_chain_i || match;
  assign data_o      = data_q;

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      CELL_DEL: begin
        // close the gap left by the removed sample
        if (del_chain_o) begin
          data_q <= right_i;
        end
      end
      CELL_INS: begin
        if (gt_o) begin
          data_q <= left_gt_i ? left_i : ctrl_i.ins;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/core/bmfp_div.sv
module bmfp_div
  import bmfp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [P_W-1:0]   dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [P_W-1:0]   quotient_o
);

  logic [DIV_W-1:0]  rem_q;
  logic [DIV_W-1:0]  dsr_q;
  logic [P_W-1:0]    quo_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;

  assign trial = {rem_q, quo_q[P_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(DIV_STEPS);
        rem_q  <= '0;
        dsr_q  <= divisor_i;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        // one quotient bit per cycle, restoring
        rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        quo_q <= {quo_q[P_W-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider busy with no steps left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i |-> rem_q < dsr_q)
    else $error("divider remainder not below divisor");

endmodule

// File: rtl/core/burst_median_frame_pacer.sv
// Burst median frame pacer.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one frame event per
// transaction; output channel (out_valid_o/out_ready_i/out_data_o) returns
// exactly one result per event, in order.
// Events are handled one at a time. A rejected event goes from the check
// straight to the result load, a later frame of a burst through the pacing
// step, and a paced one also through the deadline cap. For the first frame
// of a burst the period sample, if there is one, is inserted into a sorted
// row of 15 cells (after the oldest is removed when the row is full), the
// median is read from the middle cell, and a 32-step bit-serial divider
// makes the frame interval; the divider is the longest step. The input is
// ready again in the cycle after a result is loaded, blocked until then.
// The result sits in an output register, so a new event is taken while the
// previous result still waits. If the receiver stalls, the finished result
// of the next event holds internally and no further event is accepted until
// the output register frees up.
// Reset clears the fill count, ring position, last burst time, period,
// interval and deadline; the cell contents need no reset since only filled
// cells are read.
module burst_median_frame_pacer
  import bmfp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DEL,
    ST_INS,
    ST_MED,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_PACE,
    ST_CAP,
    ST_FIN
  } state_e;

  state_e            state_q;
  in_t               item_q;
  logic              ok_q;
  logic              wait_q;
  logic [T_W-1:0]    dl_q;
  logic [CNT_W-1:0]  fill_q;
  logic [SLOT_W-1:0] wpos_q;
  logic [T_W-1:0]    last_q;
  logic [P_W-1:0]    period_q;
  logic [P_W-1:0]    interval_q;
  logic [T_W-1:0]    target_q;
  logic [P_W-1:0]    sample_q;
  logic [T_W-1:0]    sum_q;
  logic [T_W-1:0]    cap_q;
  out_t              out_q;
  logic              out_valid_q;

  logic              ok;
  logic              first;
  logic [T_W-1:0]    diff;
  logic [P_W-1:0]    diff_sat;
  logic [T_W-1:0]    base;
  logic [T_W:0]      sum_raw;
  logic [T_W:0]      cap_raw;
  logic              div_start;
  logic              div_done;
  logic [P_W-1:0]    div_quo;
  logic              out_free;

  cell_ctrl_t        ctrl;
  cell_data_t        cell_val [WINDOW];
  logic              gt       [WINDOW];
  logic              del_ch   [WINDOW];
  cell_data_t        med_cell;

  assign ok = (item_q.burst_count >= 3'd2)
           && (item_q.burst_count <= 3'(MAX_BURST))
           && (item_q.frame_index >= 3'd1)
           && (item_q.frame_index <= item_q.burst_count);
  assign first = (item_q.frame_index == 3'd1);

  assign diff     = item_q.timestamp - last_q;
  assign diff_sat = (diff[T_W-1:P_W] != '0) ? '1 : diff[P_W-1:0];

  assign base    = first ? item_q.timestamp : target_q;
  assign sum_raw = {1'b0, base} + {{(T_W + 1 - P_W){1'b0}}, interval_q};
  assign cap_raw = {1'b0, item_q.timestamp} + {{(T_W + 1 - P_W){1'b0}}, period_q};

  // Sorted sample row.
  always_comb begin
    ctrl.op           = CELL_HOLD;
    ctrl.ins.val      = sample_q;
    ctrl.ins.slot     = wpos_q;
    ctrl.del_slot     = wpos_q;
    if (state_q == ST_DEL) begin
      ctrl.op = CELL_DEL;
    end else if (state_q == ST_INS) begin
      ctrl.op = CELL_INS;
    end
  end

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    cell_data_t left_d;
    cell_data_t right_d;
    logic       left_gt;
    logic       del_in;

    if (i == 0) begin : g_first
      assign left_d  = '0;
      assign left_gt = 1'b0;
      assign del_in  = 1'b0;
    end else begin : g_mid
      assign left_d  = cell_val[i-1];
      assign left_gt = gt[i-1];
      assign del_in  = del_ch[i-1];
    end

    if (i == WINDOW - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_next
      assign right_d = cell_val[i+1];
    end

    bmfp_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (CNT_W'(i) < fill_q),
      .left_i      (left_d),
      .right_i     (right_d),
      .left_gt_i   (left_gt),
      .del_chain_i (del_in),
      .gt_o        (gt[i]),
      .del_chain_o (del_ch[i]),
      .data_o      (cell_val[i])
    );
  end

  assign med_cell = cell_val[SLOT_W'(fill_q >> 1)];

  assign div_start = (state_q == ST_DIV_START);

  bmfp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (period_q),
    .divisor_i  (DIV_W'(item_q.burst_count) + DIV_W'(1)),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_q      <= '0;
      ok_q        <= 1'b0;
      wait_q      <= 1'b0;
      dl_q        <= '0;
      fill_q      <= '0;
      wpos_q      <= '0;
      last_q      <= '0;
      period_q    <= '0;
      interval_q  <= '0;
      target_q    <= '0;
      sample_q    <= '0;
      sum_q       <= '0;
      cap_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // in ST_FIN the load below decides valid
      if (out_valid_q && out_ready_i && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          ok_q   <= ok;
          wait_q <= 1'b0;
          dl_q   <= '0;
          if (!ok) begin
            state_q <= ST_FIN;
          end else if (first) begin
            last_q <= item_q.timestamp;
            if (last_q != '0 && item_q.timestamp > last_q) begin
              sample_q <= diff_sat;
              state_q  <= (fill_q == CNT_W'(WINDOW)) ? ST_DEL : ST_INS;
            end else begin
              state_q <= ST_DIV_START;
            end
          end else begin
            state_q <= ST_PACE;
          end
        end
        ST_DEL: begin
          // drop the oldest sample before inserting the new one
          fill_q  <= fill_q - 1'b1;
          state_q <= ST_INS;
        end
        ST_INS: begin
          fill_q  <= fill_q + 1'b1;
          wpos_q  <= (wpos_q == SLOT_W'(WINDOW - 1)) ? '0 : wpos_q + 1'b1;
          state_q <= ST_MED;
        end
        ST_MED: begin
          period_q <= med_cell.val;
          state_q  <= ST_DIV_START;
        end
        ST_DIV_START: begin
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            interval_q <= div_quo;
            state_q    <= ST_PACE;
          end
        end
        ST_PACE: begin
          if (item_q.pace && interval_q != '0) begin
            sum_q   <= sum_raw[T_W] ? '1 : sum_raw[T_W-1:0];
            cap_q   <= cap_raw[T_W] ? '1 : cap_raw[T_W-1:0];
            state_q <= ST_CAP;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_CAP: begin
          target_q <= (sum_q > cap_q) ? cap_q : sum_q;
          dl_q     <= (sum_q > cap_q) ? cap_q : sum_q;
          wait_q   <= 1'b1;
          state_q  <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_q.accepted       <= ok_q;
            out_q.wait_valid     <= wait_q;
            out_q.deadline       <= dl_q;
            out_q.median_period  <= period_q;
            out_q.frame_interval <= interval_q;
            out_valid_q          <= 1'b1;
            state_q              <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(WINDOW))
    else $error("sample count above window size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.wait_valid |-> out_q.deadline != '0)
    else $error("paced result with zero deadline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.accepted |-> !out_q.wait_valid && out_q.deadline == '0)
    else $error("rejected transaction carries a deadline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> interval_q <= period_q)
    else $error("frame interval above median period");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INS |-> fill_q < CNT_W'(WINDOW))
    else $error("insert into a full sample row");

endmodule
